[rtl/stag_pkg.sv]
// Shared types, widths and helpers for the strided tensor address generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package stag_pkg;

   localparam int NUM_DIMS   = 4;
   localparam int DIM_W      = 12;
   localparam int SIZE_W     = DIM_W + 1;
   localparam int STRIDE_W   = 24;
   localparam int ADDR_W     = 32;
   localparam int POS_W      = 32;
   localparam int RS1_W      = 2 * SIZE_W;
   localparam int RS0_W      = 3 * SIZE_W;
   localparam int TOTAL_W    = 4 * SIZE_W;
   localparam int PROD_W     = DIM_W + STRIDE_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIV_STAGES = (NUM_DIMS - 1) * DIM_W;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REQ_DW     = 80;
   localparam int RSP_DW     = 88;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic REQ_COORD    = 1'b0;
   localparam logic REQ_POSITION = 1'b1;

   typedef enum logic [2:0] {
      REG_SIZE_0   = 3'd0,
      REG_SIZE_1   = 3'd1,
      REG_SIZE_2   = 3'd2,
      REG_SIZE_3   = 3'd3,
      REG_STRIDE_0 = 3'd4,
      REG_STRIDE_1 = 3'd5,
      REG_STRIDE_2 = 3'd6,
      REG_STRIDE_3 = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [NUM_DIMS-1:0][SIZE_W-1:0]   eff_size;
      logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride;
      logic [SIZE_W-1:0]                 rs2;
      logic [RS1_W-1:0]                  rs1;
      logic [RS0_W-1:0]                  rs0;
      logic [TOTAL_W-1:0]                total;
   } cfg_type;

   typedef struct packed {
      logic                           vld;
      logic                           kind;
      logic                           err;
      logic [NUM_DIMS-1:0][DIM_W-1:0] coord;
      logic [POS_W-1:0]               rem;
   } item_type;

   typedef struct packed {
      logic                           vld;
      logic [ADDR_W-1:0]              address;
      logic [NUM_DIMS-1:0][DIM_W-1:0] coord;
      logic [1:0]                     status;
   } result_type;

   // Size as used: zero acts as one, anything past 2^DIM_W saturates.
   function automatic logic [SIZE_W-1:0] eff_size_f(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] top;
      top = {1'b1, {DIM_W{1'b0}}};
      if (s == '0) begin
         return SIZE_W'(1);
      end else if (s > top) begin
         return top;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

[rtl/stag_csr.sv]
// Configuration registers with APB-style access and the derived row-major strides.
// Depends on stag_pkg.
`default_nettype none
module stag_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [stag_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [stag_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [stag_pkg::CSR_DW-1:0] csr_prdata,
   output logic                           csr_pready,
   output stag_pkg::cfg_type              cfg,
   output logic                           busy
);
   import stag_pkg::*;

   logic [NUM_DIMS-1:0][SIZE_W-1:0]   size_ff;
   logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride_ff;
   logic [NUM_DIMS-1:0][SIZE_W-1:0]   eff;
   logic [SIZE_W-1:0]                 rs2_ff;
   logic [RS1_W-1:0]                  rs1_ff;
   logic [RS0_W-1:0]                  rs0_ff;
   logic [TOTAL_W-1:0]                total_ff;
   logic [1:0]                        settle_ff;
   logic                              wr;
   reg_index_type                     idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         eff[d] = eff_size_f(size_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            size_ff[d]   <= SIZE_W'(1);
            stride_ff[d] <= STRIDE_W'(1);
         end
         settle_ff <= 2'd3;
      end else begin
         if (wr) begin
            case (idx)
               REG_SIZE_0:   size_ff[0]   <= csr_pwdata[SIZE_W-1:0];
               REG_SIZE_1:   size_ff[1]   <= csr_pwdata[SIZE_W-1:0];
               REG_SIZE_2:   size_ff[2]   <= csr_pwdata[SIZE_W-1:0];
               REG_SIZE_3:   size_ff[3]   <= csr_pwdata[SIZE_W-1:0];
               REG_STRIDE_0: stride_ff[0] <= csr_pwdata[STRIDE_W-1:0];
               REG_STRIDE_1: stride_ff[1] <= csr_pwdata[STRIDE_W-1:0];
               REG_STRIDE_2: stride_ff[2] <= csr_pwdata[STRIDE_W-1:0];
               REG_STRIDE_3: stride_ff[3] <= csr_pwdata[STRIDE_W-1:0];
               default: ;
            endcase
            settle_ff <= 2'd3;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // Products of the sizes from the innermost outward; one multiplier each for rs1, rs0 and total.
   always_ff @(posedge clock) begin
      rs2_ff   <= eff[3];
      rs1_ff   <= RS1_W'(eff[3]) * RS1_W'(eff[2]);
      rs0_ff   <= RS0_W'(rs1_ff) * RS0_W'(eff[1]);
      total_ff <= TOTAL_W'(rs0_ff) * TOTAL_W'(eff[0]);
   end

   always_comb begin
      case (idx)
         REG_SIZE_0:   csr_prdata = CSR_DW'(size_ff[0]);
         REG_SIZE_1:   csr_prdata = CSR_DW'(size_ff[1]);
         REG_SIZE_2:   csr_prdata = CSR_DW'(size_ff[2]);
         REG_SIZE_3:   csr_prdata = CSR_DW'(size_ff[3]);
         REG_STRIDE_0: csr_prdata = CSR_DW'(stride_ff[0]);
         REG_STRIDE_1: csr_prdata = CSR_DW'(stride_ff[1]);
         REG_STRIDE_2: csr_prdata = CSR_DW'(stride_ff[2]);
         REG_STRIDE_3: csr_prdata = CSR_DW'(stride_ff[3]);
         default:      csr_prdata = '0;
      endcase
   end

   assign busy         = (settle_ff != 2'd0);
   assign cfg.eff_size = eff;
   assign cfg.stride   = stride_ff;
   assign cfg.rs2      = rs2_ff;
   assign cfg.rs1      = rs1_ff;
   assign cfg.rs0      = rs0_ff;
   assign cfg.total    = total_ff;

endmodule
`default_nettype wire

[rtl/stag_div.sv]
// Pipelined restoring divider that splits a row-major position into coordinates.
// One quotient bit per stage; depends on stag_pkg.
`default_nettype none
module stag_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  stag_pkg::cfg_type       cfg,
   input  stag_pkg::item_type      item_in,
   output stag_pkg::item_type      item_out
);
   import stag_pkg::*;

   localparam int CMP_W = RS0_W + DIM_W;

   item_type stage_ff [DIV_STAGES+1];

   assign stage_ff[0] = item_in;

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int D = j / DIM_W;
      localparam int B = DIM_W - 1 - (j % DIM_W);
      logic [RS0_W-1:0] divisor;
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] rem_wide;
      logic             ge;
      item_type         next_in;

      always_comb begin
         if (D == 0) begin
            divisor = cfg.rs0;
         end else if (D == 1) begin
            divisor = RS0_W'(cfg.rs1);
         end else begin
            divisor = RS0_W'(cfg.rs2);
         end
         shifted  = CMP_W'(divisor) << B;
         rem_wide = CMP_W'(stage_ff[j].rem);
         ge       = (rem_wide >= shifted);
         next_in  = stage_ff[j];
         if (stage_ff[j].kind == REQ_POSITION) begin
            next_in.coord[D] = {stage_ff[j].coord[D][DIM_W-2:0], ge};
            if (ge) begin
               next_in.rem = POS_W'(rem_wide - shifted);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[j+1].vld <= 1'b0;
         end else if (en) begin
            stage_ff[j+1].vld <= next_in.vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[j+1].kind  <= next_in.kind;
            stage_ff[j+1].err   <= next_in.err;
            stage_ff[j+1].coord <= next_in.coord;
            stage_ff[j+1].rem   <= next_in.rem;
         end
      end
   end

   assign item_out = stage_ff[DIV_STAGES];

endmodule
`default_nettype wire

[rtl/stag_mac.sv]
// Multiply-accumulate pipeline: coordinate times stride, sum tree and overflow check.
// Depends on stag_pkg.
`default_nettype none
module stag_mac (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  stag_pkg::cfg_type       cfg,
   input  stag_pkg::item_type      item_in,
   output stag_pkg::result_type    res_out
);
   import stag_pkg::*;

   logic [NUM_DIMS-1:0][DIM_W-1:0] coord_in;
   logic                           v1_ff, v2_ff, v3_ff;
   logic                           err1_ff, err2_ff;
   logic [NUM_DIMS-1:0][DIM_W-1:0] c1_ff, c2_ff, c3_ff;
   logic [NUM_DIMS-1:0][PROD_W-1:0] prod_ff;
   logic [PROD_W:0]                pair0_ff, pair1_ff;
   logic [ADDR_W-1:0]              addr3_ff;
   logic [1:0]                     status3_ff;
   logic [SUM_W-1:0]               sum;

   // The last remainder is the innermost coordinate; a bad position reports zeros.
   always_comb begin
      coord_in = item_in.coord;
      if (item_in.kind == REQ_POSITION) begin
         coord_in[3] = item_in.rem[DIM_W-1:0];
         if (item_in.err) begin
            coord_in = '0;
         end
      end
   end

   assign sum = SUM_W'(pair0_ff) + SUM_W'(pair1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= item_in.vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            prod_ff[d] <= PROD_W'(coord_in[d]) * PROD_W'(cfg.stride[d]);
         end
         c1_ff    <= coord_in;
         err1_ff  <= item_in.err;
         pair0_ff <= (PROD_W+1)'(prod_ff[0]) + (PROD_W+1)'(prod_ff[1]);
         pair1_ff <= (PROD_W+1)'(prod_ff[2]) + (PROD_W+1)'(prod_ff[3]);
         c2_ff    <= c1_ff;
         err2_ff  <= err1_ff;
         c3_ff    <= c2_ff;
         if (err2_ff) begin
            status3_ff <= STATUS_RANGE;
            addr3_ff   <= '0;
         end else if (sum[SUM_W-1:ADDR_W] != '0) begin
            status3_ff <= STATUS_OVERFLOW;
            addr3_ff   <= '0;
         end else begin
            status3_ff <= STATUS_OK;
            addr3_ff   <= sum[ADDR_W-1:0];
         end
      end
   end

   assign res_out.vld     = v3_ff;
   assign res_out.address = addr3_ff;
   assign res_out.coord   = c3_ff;
   assign res_out.status  = status3_ff;

endmodule
`default_nettype wire

[rtl/strided_tensor_address_gen_unit.sv]
// Strided tensor address generator, rank 4: coordinate or row-major position to address.
// One beat per cycle while the skid slot is empty and the size products are not settling.
// Depth is set by the position divider (one quotient bit per stage, 36 stages) and the
// three-stage multiply, add and overflow pipeline. After reset or any register write the
// request side holds tready low while the derived size products settle.
// Reset is synchronous and active high; registers return to size 1 and stride 1.
`default_nettype none
module strided_tensor_address_gen_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // tdata: coord_in_0, coord_in_1, coord_in_2, coord_in_3, logical_position (low bit first)
   input  wire logic [stag_pkg::REQ_DW-1:0]   req_tdata,
   // tuser: req_type
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // tdata: address, coord_out_0..3, status, zero padding (low bit first)
   output logic      [stag_pkg::RSP_DW-1:0]   rsp_tdata,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [stag_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [stag_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [stag_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import stag_pkg::*;

   cfg_type    cfg;
   logic       busy;
   logic       en;
   logic       accept;
   item_type   s0_ff;
   item_type   s0_in;
   item_type   div_out;
   result_type mac_out;
   result_type rsp_ff, skid_ff;
   logic       pop;
   logic [NUM_DIMS-1:0][DIM_W-1:0] req_coord;
   logic [POS_W-1:0] req_pos;
   logic             coord_bad;

   stag_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg),
      .busy       (busy)
   );

   // The whole pipeline moves together; it stops only when the skid slot is holding a beat,
   // so a waiting response never blocks new requests until the skid slot has filled.
   assign en         = !skid_ff.vld;
   assign req_tready = en && !busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         req_coord[d] = req_tdata[d*DIM_W +: DIM_W];
      end
      req_pos   = req_tdata[NUM_DIMS*DIM_W +: POS_W];
      coord_bad = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (SIZE_W'(req_coord[d]) >= cfg.eff_size[d]) begin
            coord_bad = 1'b1;
         end
      end
      s0_in.vld  = accept;
      s0_in.kind = req_tuser;
      if (req_tuser == REQ_COORD) begin
         s0_in.err   = coord_bad;
         s0_in.coord = req_coord;
         s0_in.rem   = '0;
      end else begin
         s0_in.err   = (TOTAL_W'(req_pos) >= cfg.total);
         s0_in.coord = '0;
         s0_in.rem   = req_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
      end else if (en) begin
         s0_ff.vld <= s0_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff.kind  <= s0_in.kind;
         s0_ff.err   <= s0_in.err;
         s0_ff.coord <= s0_in.coord;
         s0_ff.rem   <= s0_in.rem;
      end
   end

   stag_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cfg     (cfg),
      .item_in (s0_ff),
      .item_out(div_out)
   );

   stag_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .cfg    (cfg),
      .item_in(div_out),
      .res_out(mac_out)
   );

   // Output register plus one skid slot. A beat from the pipeline only arrives while the
   // skid slot is empty; it goes to the output register if that is free or draining.
   assign pop = rsp_ff.vld && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.vld  <= 1'b0;
         skid_ff.vld <= 1'b0;
      end else if (skid_ff.vld) begin
         if (pop) begin
            rsp_ff      <= skid_ff;
            skid_ff.vld <= 1'b0;
         end
      end else if (mac_out.vld) begin
         if (!rsp_ff.vld || pop) begin
            rsp_ff <= mac_out;
         end else begin
            skid_ff <= mac_out;
         end
      end else if (pop) begin
         rsp_ff.vld <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_ff.vld;
   assign rsp_tdata  = RSP_DW'({rsp_ff.status, rsp_ff.coord, rsp_ff.address});

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the strided tensor address generator unit.
// Depends on stag_pkg and strided_tensor_address_gen_unit from the rtl folder.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stag_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE       = 60;  // margin to let the pipeline empty

   // One expected or observed response beat.
   typedef struct packed {
      logic [ADDR_W-1:0]              address;
      logic [NUM_DIMS-1:0][DIM_W-1:0] coord;
      logic [1:0]                     status;
   } addr_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   strided_tensor_address_gen_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // coord_in_0..3, logical_position, low bit first
      .req_tuser   (req_tuser),   // req_type
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // address, coord_out_0..3, status, padding
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the view registers, updated as each write lands.
   logic [SIZE_W-1:0]   shadow_size[NUM_DIMS];
   logic [STRIDE_W-1:0] shadow_stride[NUM_DIMS];

   addr_beat_type pending_addrs[$];
   int   errors = 0;
   int   beats_sent = 0;
   int   beats_checked = 0;
   int   n_range = 0;
   int   n_overflow = 0;
   int   n_position = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_cycles = 0;
   longint cycle = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles, %0d beats still expected",
                  $time, cycle, pending_addrs.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Size as the block uses it: zero acts as one, large values saturate at 2^DIM_W.
   function automatic longint unsigned used_size(int d);
      if (shadow_size[d] == '0) return 1;
      if (shadow_size[d] > (1 << DIM_W)) return 1 << DIM_W;
      return shadow_size[d];
   endfunction

   // Predicts the response to one request from the shadow registers.
   function automatic addr_beat_type map_to_address(logic kind,
                                                    logic [NUM_DIMS-1:0][DIM_W-1:0] cin,
                                                    logic [POS_W-1:0] pos);
      addr_beat_type r;
      longint unsigned total, rest, sum;
      r = '0;
      r.status = STATUS_OK;
      if (kind == REQ_COORD) begin
         r.coord = cin;
         for (int d = 0; d < NUM_DIMS; d++)
            if (cin[d] >= used_size(d)) r.status = STATUS_RANGE;
      end else begin
         total = 1;
         for (int d = 0; d < NUM_DIMS; d++) total *= used_size(d);
         if (pos >= total) begin
            r.status = STATUS_RANGE;
         end else begin
            // Peel coordinates off from the innermost dimension outward.
            rest = pos;
            for (int d = NUM_DIMS - 1; d >= 0; d--) begin
               r.coord[d] = DIM_W'(rest % used_size(d));
               rest = rest / used_size(d);
            end
         end
      end
      if (r.status == STATUS_OK) begin
         sum = 0;
         for (int d = 0; d < NUM_DIMS; d++) sum += longint'(r.coord[d]) * shadow_stride[d];
         if (sum > 64'hFFFF_FFFF) r.status = STATUS_OVERFLOW;
         else r.address = sum[ADDR_W-1:0];
      end
      return r;
   endfunction

   // Counts down a long receiver hold-off requested through hold_cycles.
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // Response side: checks each accepted beat, then decides the next tready.
   always @(posedge clock) begin
      addr_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.address = rsp_tdata[ADDR_W-1:0];
         for (int d = 0; d < NUM_DIMS; d++)
            got.coord[d] = rsp_tdata[ADDR_W + DIM_W*d +: DIM_W];
         got.status = rsp_tdata[ADDR_W + NUM_DIMS*DIM_W +: 2];
         if (pending_addrs.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected: addr %h status %0d",
                     $time, got.address, got.status);
         end else begin
            want = pending_addrs.pop_front();
            beats_checked++;
            if (got.address !== want.address) begin
               errors++;
               $display("%0t: address expected %h actual %h", $time, want.address, got.address);
            end
            for (int d = 0; d < NUM_DIMS; d++)
               if (got.coord[d] !== want.coord[d]) begin
                  errors++;
                  $display("%0t: coord_out_%0d expected %0d actual %0d",
                           $time, d, want.coord[d], got.coord[d]);
               end
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
         end
      end
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one request beat and waits for it to be taken. tvalid is left high
   // so that back-to-back beats need no gap; idle cycles come before the beat.
   task automatic send_request(logic kind, logic [NUM_DIMS-1:0][DIM_W-1:0] cin,
                               logic [POS_W-1:0] pos);
      addr_beat_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pos, cin[3], cin[2], cin[1], cin[0]};
      do @(posedge clock); while (!req_tready);
      want = map_to_address(kind, cin, pos);
      pending_addrs.insert(pending_addrs.size(), want);
      beats_sent++;
      if (kind == REQ_POSITION) n_position++;
      if (want.status == STATUS_RANGE) n_range++;
      if (want.status == STATUS_OVERFLOW) n_overflow++;
   endtask

   // Waits until every expected beat has arrived and the pipeline is empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_addrs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes one register with a setup and an access cycle, then reads it back.
   task automatic write_reg(reg_index_type idx, logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx <= REG_SIZE_3) shadow_size[idx] = value[SIZE_W-1:0];
      else shadow_stride[idx - REG_STRIDE_0] = value[STRIDE_W-1:0];
      want = (idx <= REG_SIZE_3) ? CSR_DW'(value[SIZE_W-1:0]) : CSR_DW'(value[STRIDE_W-1:0]);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         errors++;
         $display("%0t: register %s read expected %h actual %h", $time, idx.name(), want,
                  csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_view(logic [SIZE_W-1:0] s0, s1, s2, s3,
                           logic [STRIDE_W-1:0] t0, t1, t2, t3);
      write_reg(REG_SIZE_0, s0);
      write_reg(REG_SIZE_1, s1);
      write_reg(REG_SIZE_2, s2);
      write_reg(REG_SIZE_3, s3);
      write_reg(REG_STRIDE_0, t0);
      write_reg(REG_STRIDE_1, t1);
      write_reg(REG_STRIDE_2, t2);
      write_reg(REG_STRIDE_3, t3);
   endtask

   // Picks a random view: mostly realistic sizes, with zero, saturating and
   // full-scale values mixed in so the odd corners keep showing up.
   task automatic random_view();
      logic [SIZE_W-1:0]   s[NUM_DIMS];
      logic [STRIDE_W-1:0] t[NUM_DIMS];
      for (int d = 0; d < NUM_DIMS; d++) begin
         case ($urandom_range(9))
            0:       s[d] = '0;
            1:       s[d] = SIZE_W'($urandom_range(8191, 4097));
            2:       s[d] = SIZE_W'(4096);
            3, 4:    s[d] = SIZE_W'(1);
            5:       s[d] = SIZE_W'($urandom_range(4095, 1));
            default: s[d] = SIZE_W'($urandom_range(64, 1));
         endcase
         case ($urandom_range(7))
            0:       t[d] = '0;
            1:       t[d] = 24'hFF_FFFF;
            2:       t[d] = STRIDE_W'($urandom);
            3:       t[d] = STRIDE_W'(1);
            default: t[d] = STRIDE_W'($urandom_range(4096, 1));
         endcase
      end
      set_view(s[0], s[1], s[2], s[3], t[0], t[1], t[2], t[3]);
   endtask

   // A random request: mostly in range, else raw bits or a position just past it.
   task automatic random_request();
      logic [NUM_DIMS-1:0][DIM_W-1:0] cin;
      logic [POS_W-1:0] pos;
      longint unsigned total;
      logic kind;
      kind  = 1'($urandom_range(1));
      total = 1;
      for (int d = 0; d < NUM_DIMS; d++) begin
         total *= used_size(d);
         cin[d] = ($urandom_range(9) == 0) ? DIM_W'($urandom)
                                           : DIM_W'($urandom_range(used_size(d) - 1));
      end
      case ($urandom_range(9))
         0:       pos = $urandom;
         1:       pos = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : POS_W'(total);
         2:       pos = POS_W'(total - 1);
         default: pos = POS_W'(longint'($urandom) % total);
      endcase
      send_request(kind, cin, pos);
   endtask

   // Registers at reset describe a single element with unit strides.
   task automatic test_reset_view();
      send_request(REQ_COORD, '0, 32'h0);
      send_request(REQ_COORD, {12'd0, 12'd0, 12'd0, 12'd1}, 32'h0);
      send_request(REQ_POSITION, '0, 32'h0);
      send_request(REQ_POSITION, '0, 32'h1);
      send_request(REQ_POSITION, '0, 32'hFFFF_FFFF);
      drain();
   endtask

   // Field extremes, overflow, range checks and size saturation.
   task automatic test_directed_corners();
      set_view(4096, 4096, 4096, 4096, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_request(REQ_COORD, {12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 32'h0);
      send_request(REQ_COORD, {12'd0, 12'd0, 12'd0, 12'd255}, 32'h0);
      send_request(REQ_COORD, {12'd0, 12'd0, 12'd0, 12'd256}, 32'h0);
      send_request(REQ_POSITION, '0, 32'hFFFF_FFFF);
      send_request(REQ_POSITION, '0, 32'h0000_0FFF);
      drain();
      // Zero acts as one and anything above 4096 saturates.
      set_view(0, 8191, 4097, 3, 24'd0, 24'd1, 24'd4096, 24'h80_0000);
      send_request(REQ_COORD, {12'd2, 12'hFFF, 12'hFFF, 12'd0}, 32'h0);
      send_request(REQ_COORD, {12'd3, 12'd0, 12'd0, 12'd0}, 32'h0);
      send_request(REQ_COORD, {12'd0, 12'd0, 12'd0, 12'd1}, 32'h0);
      send_request(REQ_POSITION, '0, 32'd50331647);
      send_request(REQ_POSITION, '0, 32'd50331648);
      send_request(REQ_POSITION, '0, 32'hAAAA_5555);
      drain();
      // Range errors next to the largest in-range coordinates and positions.
      set_view(8, 8, 8, 8, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_request(REQ_COORD, {12'd8, 12'd7, 12'd7, 12'd7}, 32'h0);
      send_request(REQ_COORD, {12'd7, 12'd7, 12'd7, 12'd7}, 32'h0);
      send_request(REQ_POSITION, '0, 32'd4095);
      send_request(REQ_POSITION, '0, 32'd4096);
      drain();
   endtask

   // Random views and requests under one handshake pressure setting.
   task automatic test_random_traffic(int idle_pct, int stall_pct, int items);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < items; i++) begin
         if (i % 90 == 0) begin
            drain();
            random_view();
         end
         random_request();
      end
      drain();
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the pipeline fills and the request side has to stall.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_view(16, 16, 16, 16, 24'd4096, 24'd256, 24'd16, 24'd1);
      @(posedge clock);
      hold_cycles <= 300;
      for (int i = 0; i < 130; i++) random_request();
      drain();
   endtask

   initial begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         shadow_size[d]   = SIZE_W'(1);
         shadow_stride[d] = STRIDE_W'(1);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_view();
      test_directed_corners();
      test_random_traffic(0, 0, 450);
      test_random_traffic(84, 0, 450);
      test_random_traffic(0, 84, 450);
      test_random_traffic(15, 15, 450);
      test_backpressure();
      $display("Covered %0d request beats (%0d by position), %0d range errors, %0d overflows,",
               beats_sent, n_position, n_range, n_overflow);
      $display("over random views, four idle and stall mixes and a long receiver hold-off.");
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
